// ===== rtl/lottery_scheduler_burst_weighted_core_macros.svh =====
// Assertion helpers; clk and arst_n must be visible at the point of use.
`ifndef LOTTERY_SCHEDULER_BURST_WEIGHTED_CORE_MACROS_SVH
`define LOTTERY_SCHEDULER_BURST_WEIGHTED_CORE_MACROS_SVH

// same-cycle implication
`define LSBW_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsbw: same-cycle check failed");

// next-cycle implication
`define LSBW_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsbw: next-cycle check failed");

`endif

// ===== rtl/lsbw_pkg.sv =====
package lsbw_pkg;

	localparam int IDX_W    = 3;
	localparam int BURST_W  = 16;
	localparam int TICKET_W = 7;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_DRAW = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_CHECK,
		ST_WALK_RD,
		ST_WALK_LD,
		ST_DIV,
		ST_CMP,
		ST_DONE
	} lsbw_state_t;

	typedef struct packed {
		logic start;
		logic load_wr;
		logic sum_acc;
		logic ptr_clr;
		logic ptr_inc;
		logic div_load;
		logic div_step;
		logic cmp;
		logic publish;
	} lsbw_cmd_t;

	typedef struct packed {
		logic last;
		logic total_zero;
		logic rem_zero;
		logic div_done;
		logic hit;
		logic out_free;
	} lsbw_sts_t;

endpackage

// ===== rtl/lsbw_item_if.sv =====
interface lsbw_item_if;
	import lsbw_pkg::*;

	logic                valid;
	logic                ready;
	logic                action;
	logic [IDX_W-1:0]    entry_index;
	logic [BURST_W-1:0]  burst_value;
	logic [TICKET_W-1:0] draw_ticket;

	modport source(output valid, action, entry_index, burst_value, draw_ticket, input ready);
	modport sink(input valid, action, entry_index, burst_value, draw_ticket, output ready);
endinterface

// ===== rtl/lsbw_result_if.sv =====
interface lsbw_result_if;
	import lsbw_pkg::*;

	logic               valid;
	logic               ready;
	logic               winner_found;
	logic [IDX_W-1:0]   winner_index;
	logic [BURST_W-1:0] winner_remaining;

	modport source(output valid, winner_found, winner_index, winner_remaining, input ready);
	modport sink(input valid, winner_found, winner_index, winner_remaining, output ready);
endinterface

// ===== rtl/lottery_scheduler_burst_weighted_core.sv =====
// Burst-weighted lottery scheduler.
// item channel (valid/ready): action 0 loads burst_value into entry
// entry_index (an index beyond the table is dropped); action 1 draws with
// draw_ticket. A load beat gives no result; a draw beat gives one result beat.
// result channel (valid/ready): winner_found, winner_index and the winner's
// count after its decrement; all zero when no ticket range holds the draw.
// A load is done in the cycle it is accepted. A draw sums the table entry
// by entry (read, then accumulate), then walks the entries: an entry with a
// zero count is read and skipped, and for each nonzero entry the share is
// found by a bit-serial restoring divider and compared with the ticket.
// One draw is in flight at a time.
// Reset clears the table to all zero through per-entry written flags; no
// sweep is needed and the block is ready at once.
// The result sits in an output register; a finished draw waits in the done
// state while the receiver stalls, and the next item is accepted once it is published.
`include "lottery_scheduler_burst_weighted_core_macros.svh"

module lottery_scheduler_burst_weighted_core #(
	parameter int PROCESS_COUNT = 8,
	parameter int TICKET_POOL   = 100
) (
	input logic          clk,
	input logic          arst_n,
	lsbw_item_if.sink    item,
	lsbw_result_if.source result
);
	import lsbw_pkg::*;

	lsbw_cmd_t cmd;
	lsbw_sts_t sts;

	lsbw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_action(item.action),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	lsbw_dp #(
		.PROCESS_COUNT(PROCESS_COUNT),
		.TICKET_POOL  (TICKET_POOL)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.entry_index  (item.entry_index),
		.burst_value  (item.burst_value),
		.draw_ticket  (item.draw_ticket),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.out_found    (result.winner_found),
		.out_index    (result.winner_index),
		.out_remaining(result.winner_remaining)
	);

	`LSBW_ASSERT_NXT(a_draw_busy, item.valid && item.ready && item.action == ACT_DRAW, !item.ready)
	`LSBW_ASSERT_IMP(a_publish_free, cmd.publish, !result.valid || result.ready)
	`LSBW_ASSERT_IMP(a_nowin_zero, result.valid && !result.winner_found,
		result.winner_index == '0 && result.winner_remaining == '0)
	`LSBW_ASSERT_IMP(a_hit_nonzero, cmd.cmp && sts.hit, !sts.total_zero)
endmodule

// ===== rtl/lsbw_ram.sv =====
module lsbw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/lsbw_ctrl.sv =====
module lsbw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_action,
	output logic              item_ready,
	input  lsbw_pkg::lsbw_sts_t sts,
	output lsbw_pkg::lsbw_cmd_t cmd
);
	import lsbw_pkg::*;

	lsbw_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && item_action == ACT_DRAW) state_d = ST_SUM_RD;
			end
			ST_SUM_RD:  state_d = ST_SUM_ACC;
			ST_SUM_ACC: state_d = sts.last ? ST_CHECK : ST_SUM_RD;
			ST_CHECK:   state_d = sts.total_zero ? ST_DONE : ST_WALK_RD;
			ST_WALK_RD: state_d = ST_WALK_LD;
			ST_WALK_LD: begin
				if (!sts.rem_zero) state_d = ST_DIV;
				else if (sts.last) state_d = ST_DONE;
				else state_d = ST_WALK_RD;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_CMP;
			end
			ST_CMP: state_d = (sts.hit || sts.last) ? ST_DONE : ST_WALK_RD;
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.start   = item_valid && item_action == ACT_DRAW;
				cmd.load_wr = item_valid && item_action == ACT_LOAD;
			end
			ST_SUM_RD: ;
			ST_SUM_ACC: begin
				cmd.sum_acc = 1'b1;
				cmd.ptr_inc = !sts.last;
			end
			ST_CHECK:   cmd.ptr_clr = 1'b1;
			ST_WALK_RD: ;
			ST_WALK_LD: begin
				cmd.div_load = !sts.rem_zero;
				cmd.ptr_inc  = sts.rem_zero && !sts.last;
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_CMP: begin
				cmd.cmp     = 1'b1;
				cmd.ptr_inc = !sts.hit && !sts.last;
			end
			ST_DONE: cmd.publish = sts.out_free;
			default: ;
		endcase
	end
endmodule

// ===== rtl/lsbw_dp.sv =====
module lsbw_dp #(
	parameter int PROCESS_COUNT = 8,
	parameter int TICKET_POOL   = 100
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lsbw_pkg::lsbw_cmd_t             cmd,
	output lsbw_pkg::lsbw_sts_t             sts,
	input  logic [lsbw_pkg::IDX_W-1:0]      entry_index,
	input  logic [lsbw_pkg::BURST_W-1:0]    burst_value,
	input  logic [lsbw_pkg::TICKET_W-1:0]   draw_ticket,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            out_found,
	output logic [lsbw_pkg::IDX_W-1:0]      out_index,
	output logic [lsbw_pkg::BURST_W-1:0]    out_remaining
);
	import lsbw_pkg::*;

	localparam int AW     = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
	localparam int QW     = $clog2(TICKET_POOL + 1);
	localparam int NUM_W  = BURST_W + QW;
	localparam int TOT_W  = BURST_W + $clog2(PROCESS_COUNT + 1);
	localparam int CNT_W  = $clog2(QW + 1);
	localparam int CMP_W  = (QW + 1 > TICKET_W) ? QW + 1 : TICKET_W;

	logic [AW-1:0]       ptr_q;
	logic [TOT_W-1:0]    total_q;
	logic [QW-1:0]       given_q;
	logic [TICKET_W-1:0] ticket_q;
	logic [TOT_W-1:0]    prem_q;
	logic [QW-1:0]       qsh_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [BURST_W-1:0]  rem_q;
	logic                win_found_q;
	logic [IDX_W-1:0]    win_idx_q;
	logic [BURST_W-1:0]  win_rem_q;
	logic                out_valid_q;
	logic                out_found_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic [BURST_W-1:0]  out_rem_q;
	logic [PROCESS_COUNT-1:0] vld_q;
	logic                vld_rd_q;

	logic [BURST_W-1:0]  rdata;
	logic [BURST_W-1:0]  rd_rem;
	logic [6:0]          idx_ext;
	logic [6:0]          ptr_ext;
	logic                in_range;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [BURST_W-1:0]  wdata;
	logic [NUM_W-1:0]    prod;
	logic [TOT_W:0]      trial;
	logic                ge;
	logic [CMP_W-1:0]    tk_c, given_c, end_c;
	logic                hit;

	assign idx_ext  = 7'(entry_index);
	assign ptr_ext  = 7'(ptr_q);
	assign in_range = idx_ext < 7'(PROCESS_COUNT);
	assign rd_rem   = vld_rd_q ? rdata : '0;
	assign prod     = NUM_W'(rd_rem) * NUM_W'(TICKET_POOL);
	assign trial    = {prem_q, qsh_q[QW-1]};
	assign ge       = trial >= (TOT_W + 1)'(total_q);
	assign tk_c     = CMP_W'(ticket_q);
	assign given_c  = CMP_W'(given_q);
	assign end_c    = given_c + CMP_W'(qsh_q);
	assign hit      = (tk_c >= given_c) && (tk_c < end_c);

	assign we    = (cmd.load_wr && in_range) || (cmd.cmp && hit);
	assign waddr = cmd.load_wr ? idx_ext[AW-1:0] : ptr_q;
	assign wdata = cmd.load_wr ? burst_value : rem_q - BURST_W'(1);

	lsbw_ram #(
		.WIDTH(BURST_W),
		.DEPTH(PROCESS_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(ptr_q),
		.rdata(rdata)
	);

	// per-entry written flags stand in for clearing the table at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (we) vld_q[waddr] <= 1'b1;
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		vld_rd_q <= vld_q[ptr_q];

		if (cmd.start || cmd.ptr_clr) ptr_q <= '0;
		else if (cmd.ptr_inc) ptr_q <= ptr_q + AW'(1);

		if (cmd.start) begin
			total_q     <= '0;
			given_q     <= '0;
			ticket_q    <= draw_ticket;
			win_found_q <= 1'b0;
			win_idx_q   <= '0;
			win_rem_q   <= '0;
		end else begin
			if (cmd.sum_acc) total_q <= total_q + TOT_W'(rd_rem);
			if (cmd.cmp) begin
				if (hit) begin
					win_found_q <= 1'b1;
					win_idx_q   <= ptr_ext[IDX_W-1:0];
					win_rem_q   <= rem_q - BURST_W'(1);
				end else begin
					given_q <= QW'(end_c);
				end
			end
		end

		// restoring divide, quotient bits shift in below the dividend low bits
		if (cmd.div_load) begin
			rem_q  <= rd_rem;
			prem_q <= TOT_W'(prod[NUM_W-1:QW]);
			qsh_q  <= prod[QW-1:0];
			cnt_q  <= CNT_W'(QW);
		end else if (cmd.div_step) begin
			prem_q <= ge ? TOT_W'(trial - (TOT_W + 1)'(total_q)) : TOT_W'(trial);
			qsh_q  <= {qsh_q[QW-2:0], ge};
			cnt_q  <= cnt_q - CNT_W'(1);
		end

		if (cmd.publish) begin
			out_found_q <= win_found_q;
			out_idx_q   <= win_idx_q;
			out_rem_q   <= win_rem_q;
		end
	end

	assign sts.last       = ptr_q == AW'(PROCESS_COUNT - 1);
	assign sts.total_zero = total_q == '0;
	assign sts.rem_zero   = rd_rem == '0;
	assign sts.div_done   = cnt_q == CNT_W'(1);
	assign sts.hit        = hit;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign out_found     = out_found_q;
	assign out_index     = out_idx_q;
	assign out_remaining = out_rem_q;
endmodule
